[hw/rtl/bvma_pkg.sv]
// shared constants, stage types and the size helper for the volume moment accumulator
`default_nettype none

package bvma_pkg;

   localparam int MAX_DIM   = 1024;
   localparam int POS_W     = $clog2(MAX_DIM);
   localparam int CFG_W     = 11;
   localparam int VAL_W     = 16;
   localparam int CNT_W     = 31;
   localparam int SUM1_W    = 40;
   localparam int SUM2_W    = 50;
   localparam int PROD_W    = 2 * POS_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SIZE = 2'd0,
      CSR_Y_SIZE = 2'd1,
      CSR_Z_SIZE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic             hit;
      logic             last;
      logic [POS_W-1:0] x;
      logic [POS_W-1:0] y;
      logic [POS_W-1:0] z;
   } coord_stage_type;

   typedef struct packed {
      logic              valid;
      logic              hit;
      logic              last;
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [POS_W-1:0]  z;
      logic [PROD_W-1:0] xx;
      logic [PROD_W-1:0] xy;
      logic [PROD_W-1:0] xz;
      logic [PROD_W-1:0] yy;
      logic [PROD_W-1:0] yz;
      logic [PROD_W-1:0] zz;
   } prod_stage_type;

   // highest coordinate along one axis: zero size acts as one, oversize clamps
   function automatic logic [POS_W-1:0] size_limit(input logic [CFG_W-1:0] size);
      logic [POS_W-1:0] limit;
      if (size == '0) begin
         limit = '0;
      end else if (int'(size) > MAX_DIM) begin
         limit = POS_W'(MAX_DIM - 1);
      end else begin
         limit = POS_W'(size - 1'b1);
      end
      return limit;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/bvma_req_if.sv]
// voxel input channel
`default_nettype none

interface bvma_req_if;
   import bvma_pkg::*;

   logic             valid;
   logic             ready;
   logic [VAL_W-1:0] voxel_value;

   modport source (output valid, output voxel_value, input ready);
   modport sink   (input valid, input voxel_value, output ready);
endinterface

`default_nettype wire

[hw/rtl/bvma_rsp_if.sv]
// moment result channel
`default_nettype none

interface bvma_rsp_if;
   import bvma_pkg::*;

   logic              valid;
   logic              ready;
   logic [CNT_W-1:0]  voxel_count;
   logic [SUM1_W-1:0] sum_x;
   logic [SUM1_W-1:0] sum_y;
   logic [SUM1_W-1:0] sum_z;
   logic [SUM2_W-1:0] sum_xx;
   logic [SUM2_W-1:0] sum_xy;
   logic [SUM2_W-1:0] sum_xz;
   logic [SUM2_W-1:0] sum_yy;
   logic [SUM2_W-1:0] sum_yz;
   logic [SUM2_W-1:0] sum_zz;

   modport source (output valid, output voxel_count, output sum_x, output sum_y,
                   output sum_z, output sum_xx, output sum_xy, output sum_xz,
                   output sum_yy, output sum_yz, output sum_zz, input ready);
   modport sink   (input valid, input voxel_count, input sum_x, input sum_y,
                   input sum_z, input sum_xx, input sum_xy, input sum_xz,
                   input sum_yy, input sum_yz, input sum_zz, output ready);
endinterface

`default_nettype wire

[hw/rtl/bvma_coord.sv]
// size registers, raster coordinate counters and the input stage register
`default_nettype none

module bvma_coord (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [bvma_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bvma_pkg::CFG_W-1:0]     csr_write_data,
   bvma_req_if.sink                           req_stream,
   input  wire logic                          advance,
   output bvma_pkg::coord_stage_type          coord_out
);
   import bvma_pkg::*;

   logic [CFG_W-1:0] x_size_ff, x_size_in;
   logic [CFG_W-1:0] y_size_ff, y_size_in;
   logic [CFG_W-1:0] z_size_ff, z_size_in;
   logic [POS_W-1:0] pos_x_ff, pos_x_in;
   logic [POS_W-1:0] pos_y_ff, pos_y_in;
   logic [POS_W-1:0] pos_z_ff, pos_z_in;
   coord_stage_type  stage_ff, stage_in;

   logic end_x, end_y, end_z, last_voxel, accept;

   always_comb begin
      x_size_in = x_size_ff;
      y_size_in = y_size_ff;
      z_size_in = z_size_ff;
      if (csr_write_en) begin
         if (csr_index == CSR_X_SIZE) begin
            x_size_in = csr_write_data;
         end else if (csr_index == CSR_Y_SIZE) begin
            y_size_in = csr_write_data;
         end else if (csr_index == CSR_Z_SIZE) begin
            z_size_in = csr_write_data;
         end
      end
   end

   // >= so that a counter past a shrunken size wraps at once
   assign end_x      = pos_x_ff >= size_limit(x_size_ff);
   assign end_y      = pos_y_ff >= size_limit(y_size_ff);
   assign end_z      = pos_z_ff >= size_limit(z_size_ff);
   assign last_voxel = end_x && end_y && end_z;

   assign req_stream.ready = advance;
   assign accept           = req_stream.valid && advance;

   always_comb begin
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      pos_z_in = pos_z_ff;
      if (accept) begin
         if (last_voxel) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
         end else if (!end_x) begin
            pos_x_in = pos_x_ff + 1'b1;
         end else begin
            pos_x_in = '0;
            if (!end_y) begin
               pos_y_in = pos_y_ff + 1'b1;
            end else begin
               pos_y_in = '0;
               pos_z_in = pos_z_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid = accept;
         stage_in.hit   = req_stream.voxel_value != '0;
         stage_in.last  = last_voxel;
         stage_in.x     = pos_x_ff;
         stage_in.y     = pos_y_ff;
         stage_in.z     = pos_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_size_ff <= SIZE_RESET;
         y_size_ff <= SIZE_RESET;
         z_size_ff <= SIZE_RESET;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         stage_ff  <= '0;
      end else begin
         x_size_ff <= x_size_in;
         y_size_ff <= y_size_in;
         z_size_ff <= z_size_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         stage_ff  <= stage_in;
      end
   end

   assign coord_out = stage_ff;

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (accept && last_voxel) |=> (pos_x_ff == '0 && pos_y_ff == '0 && pos_z_ff == '0))
      else $error("coordinates not cleared after last item of volume");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> ($stable(pos_x_ff) && $stable(pos_y_ff) && $stable(pos_z_ff)))
      else $error("coordinates moved without an accepted item");

endmodule

`default_nettype wire

[hw/rtl/bvma_product.sv]
// coordinate product stage
`default_nettype none

module bvma_product (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  bvma_pkg::coord_stage_type coord_in,
   output bvma_pkg::prod_stage_type  prod_out
);
   import bvma_pkg::*;

   prod_stage_type stage_ff, stage_in;

   always_comb begin
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid = coord_in.valid;
         stage_in.hit   = coord_in.hit;
         stage_in.last  = coord_in.last;
         stage_in.x     = coord_in.x;
         stage_in.y     = coord_in.y;
         stage_in.z     = coord_in.z;
         stage_in.xx    = PROD_W'(coord_in.x) * PROD_W'(coord_in.x);
         stage_in.xy    = PROD_W'(coord_in.x) * PROD_W'(coord_in.y);
         stage_in.xz    = PROD_W'(coord_in.x) * PROD_W'(coord_in.z);
         stage_in.yy    = PROD_W'(coord_in.y) * PROD_W'(coord_in.y);
         stage_in.yz    = PROD_W'(coord_in.y) * PROD_W'(coord_in.z);
         stage_in.zz    = PROD_W'(coord_in.z) * PROD_W'(coord_in.z);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   assign prod_out = stage_ff;

endmodule

`default_nettype wire

[hw/rtl/bvma_accum.sv]
// moment accumulators and the result register
`default_nettype none

module bvma_accum (
   input  wire logic                clock,
   input  wire logic                reset,
   input  bvma_pkg::prod_stage_type prod_in,
   output logic                     advance,
   bvma_rsp_if.source               rsp_stream
);
   import bvma_pkg::*;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM1_W-1:0] sum1_ff [3];
   logic [SUM1_W-1:0] sum1_in [3];
   logic [SUM2_W-1:0] sum2_ff [6];
   logic [SUM2_W-1:0] sum2_in [6];

   logic [CNT_W-1:0]  count_add;
   logic [SUM1_W-1:0] sum1_add [3];
   logic [SUM2_W-1:0] sum2_add [6];
   logic [SUM1_W-1:0] term1 [3];
   logic [SUM2_W-1:0] term2 [6];

   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [SUM1_W-1:0] rsp_sum1_ff [3];
   logic [SUM1_W-1:0] rsp_sum1_in [3];
   logic [SUM2_W-1:0] rsp_sum2_ff [6];
   logic [SUM2_W-1:0] rsp_sum2_in [6];

   logic out_busy, take;

   // only a finished volume waiting on a full result register stalls the pipe
   assign out_busy = rsp_valid_ff && !rsp_stream.ready;
   assign advance  = !(prod_in.valid && prod_in.last && out_busy);
   assign take     = prod_in.valid && advance;

   assign term1[0] = SUM1_W'(prod_in.x);
   assign term1[1] = SUM1_W'(prod_in.y);
   assign term1[2] = SUM1_W'(prod_in.z);
   assign term2[0] = SUM2_W'(prod_in.xx);
   assign term2[1] = SUM2_W'(prod_in.xy);
   assign term2[2] = SUM2_W'(prod_in.xz);
   assign term2[3] = SUM2_W'(prod_in.yy);
   assign term2[4] = SUM2_W'(prod_in.yz);
   assign term2[5] = SUM2_W'(prod_in.zz);

   always_comb begin
      count_add = count_ff + CNT_W'(prod_in.hit);
      for (int i = 0; i < 3; i++) begin
         sum1_add[i] = prod_in.hit ? sum1_ff[i] + term1[i] : sum1_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         sum2_add[i] = prod_in.hit ? sum2_ff[i] + term2[i] : sum2_ff[i];
      end
   end

   always_comb begin
      count_in     = count_ff;
      sum1_in      = sum1_ff;
      sum2_in      = sum2_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sum1_in  = rsp_sum1_ff;
      rsp_sum2_in  = rsp_sum2_ff;
      rsp_valid_in = rsp_stream.ready ? 1'b0 : rsp_valid_ff;
      if (take) begin
         if (prod_in.last) begin
            rsp_valid_in = 1'b1;
            rsp_count_in = count_add;
            rsp_sum1_in  = sum1_add;
            rsp_sum2_in  = sum2_add;
            count_in     = '0;
            for (int i = 0; i < 3; i++) begin
               sum1_in[i] = '0;
            end
            for (int i = 0; i < 6; i++) begin
               sum2_in[i] = '0;
            end
         end else begin
            count_in = count_add;
            sum1_in  = sum1_add;
            sum2_in  = sum2_add;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int i = 0; i < 3; i++) begin
            sum1_ff[i] <= '0;
         end
         for (int i = 0; i < 6; i++) begin
            sum2_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         sum1_ff      <= sum1_in;
         sum2_ff      <= sum2_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_sum1_ff  <= rsp_sum1_in;
      rsp_sum2_ff  <= rsp_sum2_in;
   end

   assign rsp_stream.valid       = rsp_valid_ff;
   assign rsp_stream.voxel_count = rsp_count_ff;
   assign rsp_stream.sum_x       = rsp_sum1_ff[0];
   assign rsp_stream.sum_y       = rsp_sum1_ff[1];
   assign rsp_stream.sum_z       = rsp_sum1_ff[2];
   assign rsp_stream.sum_xx      = rsp_sum2_ff[0];
   assign rsp_stream.sum_xy      = rsp_sum2_ff[1];
   assign rsp_stream.sum_xz      = rsp_sum2_ff[2];
   assign rsp_stream.sum_yy      = rsp_sum2_ff[3];
   assign rsp_stream.sum_yz      = rsp_sum2_ff[4];
   assign rsp_stream.sum_zz      = rsp_sum2_ff[5];

   a_cleared_on_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> (count_ff == '0 && sum1_ff[0] == '0 && sum2_ff[5] == '0))
      else $error("accumulators not cleared when result was loaded");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(count_ff) && $stable(sum1_ff[0]) && $stable(sum2_ff[0])))
      else $error("accumulators changed while pipe was stalled");

   a_empty_sums: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (sum1_ff[0] == '0 && sum1_ff[1] == '0 && sum1_ff[2] == '0
                            && sum2_ff[0] == '0 && sum2_ff[3] == '0 && sum2_ff[5] == '0))
      else $error("coordinate sums nonzero with no counted item");

endmodule

`default_nettype wire

[hw/rtl/binary_volume_moment_accumulator_core.sv]
// Volume moment accumulator top level.
// The last voxel of a volume is registered in the input stage on accept, then in the product stage,
// then accumulated into the result register, which raises valid; a stall can hold it between stages.
// Throughput: one voxel per cycle; input stalls only while a finished result is
// still held and the next volume's last voxel reaches the accumulators.
// Reset: sizes return to 256, coordinates and all sums clear, no result pending.
`default_nettype none

module binary_volume_moment_accumulator_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic [bvma_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bvma_pkg::CFG_W-1:0]     csr_write_data,
   bvma_req_if.sink                           req_stream,
   bvma_rsp_if.source                         rsp_stream
);
   import bvma_pkg::*;

   coord_stage_type coord_stage;
   prod_stage_type  prod_stage;
   logic            advance;

   bvma_coord u_coord (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_stream     (req_stream),
      .advance        (advance),
      .coord_out      (coord_stage)
   );

   bvma_product u_product (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .coord_in (coord_stage),
      .prod_out (prod_stage)
   );

   bvma_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .prod_in    (prod_stage),
      .advance    (advance),
      .rsp_stream (rsp_stream)
   );

endmodule

`default_nettype wire

[tb/sv/bvma_moment_checker.sv]
// checker for the volume moment accumulator: predicts the moments and compares results
`default_nettype none

module bvma_moment_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [bvma_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bvma_pkg::CFG_W-1:0]     csr_write_data,
   bvma_req_if                                 req_mon,
   bvma_rsp_if                                 rsp_mon,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output logic                                volume_open
);
   import bvma_pkg::*;

   typedef struct packed {
      logic [CNT_W-1:0]  voxel_count;
      logic [SUM1_W-1:0] sum_x;
      logic [SUM1_W-1:0] sum_y;
      logic [SUM1_W-1:0] sum_z;
      logic [SUM2_W-1:0] sum_xx;
      logic [SUM2_W-1:0] sum_xy;
      logic [SUM2_W-1:0] sum_xz;
      logic [SUM2_W-1:0] sum_yy;
      logic [SUM2_W-1:0] sum_yz;
      logic [SUM2_W-1:0] sum_zz;
   } moments_type;

   logic [CFG_W-1:0] x_size_reg;
   logic [CFG_W-1:0] y_size_reg;
   logic [CFG_W-1:0] z_size_reg;
   logic [POS_W-1:0] at_x;
   logic [POS_W-1:0] at_y;
   logic [POS_W-1:0] at_z;
   moments_type      running;
   moments_type      expected_moments[$];
   int               errors = 0;

   initial begin
      mismatch_count = 0;
      pending_count  = 0;
      volume_open    = 1'b0;
   end

   // zero acts as one voxel, oversize clamps to the largest dimension
   function automatic int last_index(input logic [CFG_W-1:0] size);
      int n;
      n = int'(size);
      if (n == 0) begin
         n = 1;
      end else if (n > MAX_DIM) begin
         n = MAX_DIM;
      end
      return n - 1;
   endfunction

   task automatic absorb_voxel(input logic [VAL_W-1:0] value);
      logic [SUM2_W-1:0] wx;
      logic [SUM2_W-1:0] wy;
      logic [SUM2_W-1:0] wz;
      logic              end_x;
      logic              end_y;
      logic              end_z;
      wx = SUM2_W'(at_x);
      wy = SUM2_W'(at_y);
      wz = SUM2_W'(at_z);
      if (value != '0) begin
         running.voxel_count += 1'b1;
         running.sum_x       += SUM1_W'(at_x);
         running.sum_y       += SUM1_W'(at_y);
         running.sum_z       += SUM1_W'(at_z);
         running.sum_xx      += wx * wx;
         running.sum_xy      += wx * wy;
         running.sum_xz      += wx * wz;
         running.sum_yy      += wy * wy;
         running.sum_yz      += wy * wz;
         running.sum_zz      += wz * wz;
      end
      // a counter beyond a shrunken size wraps at once
      end_x = int'(at_x) >= last_index(x_size_reg);
      end_y = int'(at_y) >= last_index(y_size_reg);
      end_z = int'(at_z) >= last_index(z_size_reg);
      if (end_x && end_y && end_z) begin
         expected_moments.push_back(running);
         running = '0;
         at_x    = '0;
         at_y    = '0;
         at_z    = '0;
      end else if (!end_x) begin
         at_x = at_x + 1'b1;
      end else begin
         at_x = '0;
         if (!end_y) begin
            at_y = at_y + 1'b1;
         end else begin
            at_y = '0;
            at_z = at_z + 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         if (errors < 10) begin
            $display("mismatch in %s: expected %0d, got %0d", name, want, got);
         end
         errors++;
      end
   endtask

   always @(posedge clock) begin
      moments_type want;
      if (reset) begin
         x_size_reg = SIZE_RESET;
         y_size_reg = SIZE_RESET;
         z_size_reg = SIZE_RESET;
         at_x       = '0;
         at_y       = '0;
         at_z       = '0;
         running    = '0;
         expected_moments.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            absorb_voxel(req_mon.voxel_value);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_moments.size() == 0) begin
               if (errors < 10) begin
                  $display("result item with no expectation: count %0d",
                           rsp_mon.voxel_count);
               end
               errors++;
            end else begin
               want = expected_moments.pop_front();
               check_field("voxel_count", 64'(want.voxel_count), 64'(rsp_mon.voxel_count));
               check_field("sum_x", 64'(want.sum_x), 64'(rsp_mon.sum_x));
               check_field("sum_y", 64'(want.sum_y), 64'(rsp_mon.sum_y));
               check_field("sum_z", 64'(want.sum_z), 64'(rsp_mon.sum_z));
               check_field("sum_xx", 64'(want.sum_xx), 64'(rsp_mon.sum_xx));
               check_field("sum_xy", 64'(want.sum_xy), 64'(rsp_mon.sum_xy));
               check_field("sum_xz", 64'(want.sum_xz), 64'(rsp_mon.sum_xz));
               check_field("sum_yy", 64'(want.sum_yy), 64'(rsp_mon.sum_yy));
               check_field("sum_yz", 64'(want.sum_yz), 64'(rsp_mon.sum_yz));
               check_field("sum_zz", 64'(want.sum_zz), 64'(rsp_mon.sum_zz));
            end
         end
         // counters are left alone by a size write; unknown indexes are ignored
         if (csr_write_en) begin
            case (csr_index)
               CSR_X_SIZE: x_size_reg = csr_write_data;
               CSR_Y_SIZE: y_size_reg = csr_write_data;
               CSR_Z_SIZE: z_size_reg = csr_write_data;
               default: ;
            endcase
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_moments.size();
      volume_open    <= (at_x != '0) || (at_y != '0) || (at_z != '0);
   end

endmodule

`default_nettype wire

[tb/sv/tb_binary_volume_moment_accumulator_core.sv]
// top-level testbench for the volume moment accumulator: stimulus, watchdog and verdict
`default_nettype none

module tb_binary_volume_moment_accumulator_core;
   import bvma_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_VOXELS = 520;
   localparam int BIG_SIZE      = 2047;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;
   int                   mismatch_count;
   int                   pending_count;
   logic                 volume_open;
   int                   burst_left = 0;
   int                   idle_cycles = 0;

   bvma_req_if req_if ();
   bvma_rsp_if rsp_if ();

   binary_volume_moment_accumulator_core uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_stream     (req_if),
      .rsp_stream     (rsp_if)
   );

   bvma_moment_checker moment_check (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .volume_open    (volume_open)
   );

   always #5 clock = ~clock;

   // cycles with no item moving on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // result side stalls in modes that are picked at random from time to time
   initial begin
      int mode;
      int cyc;
      mode = 0;
      cyc  = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (cyc % 64 == 0) begin
            mode = $urandom_range(0, 3);
         end
         case (mode)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= 1'($urandom_range(0, 1));
            2: rsp_if.ready <= (cyc % 5 == 0);
            default: rsp_if.ready <= (cyc % 16 == 15);
         endcase
         cyc++;
      end
   end

   function automatic int axis_length(input int v);
      return (v == 0) ? 1 : ((v > MAX_DIM) ? MAX_DIM : v);
   endfunction

   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(0, 7))
         0, 1, 2: return '0;
         3: return '1;
         default: return VAL_W'($urandom_range(1, 65535));
      endcase
   endfunction

   // valid stays high across a burst; a gap is only taken before raising it
   task automatic send_voxel(input logic [VAL_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_if.valid       <= 1'b1;
      req_if.voxel_value <= value;
      do @(posedge clock); while (!req_if.ready);
      burst_left--;
   endtask

   task automatic run_voxels(input int n);
      repeat (n) send_voxel(random_value());
   endtask

   task automatic write_size(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= CFG_W'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_volume(input int xs, input int ys, input int zs);
      write_size(CSR_X_SIZE, xs);
      write_size(CSR_Y_SIZE, ys);
      write_size(CSR_Z_SIZE, zs);
   endtask

   // wait for every expected result, then let the pipeline drain
   task automatic settle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [VAL_W-1:0] pattern [12];
      int xs;
      int ys;
      int zs;
      int total;
      int part;
      int sent;
      pattern = '{16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h00FF, 16'h0000,
                  16'hFF00, 16'h5555, 16'hAAAA, 16'h0000, 16'h0001, 16'hFFFF};
      req_if.valid       <= 1'b0;
      req_if.voxel_value <= '0;
      csr_write_en       <= 1'b0;
      csr_index          <= CSR_X_SIZE;
      csr_write_data     <= '0;
      reset              <= 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero sizes give a one-voxel volume; the unused index must not alias
      set_volume(0, 0, 0);
      write_size(CSR_UNUSED, 7);
      send_voxel('0);
      send_voxel('1);
      send_voxel(16'h0001);
      settle();

      set_volume(3, 2, 2);
      foreach (pattern[i]) send_voxel(pattern[i]);
      settle();

      // shrink x while the counter sits beyond the new size
      set_volume(4, 2, 1);
      run_voxels(3);
      settle();
      write_size(CSR_X_SIZE, 2);
      run_voxels(3);
      settle();

      sent = 0;
      while (sent < RANDOM_VOXELS) begin
         case ($urandom_range(0, 7))
            0: begin
               xs = $urandom_range(6, 40);
               ys = $urandom_range(0, 2);
               zs = $urandom_range(0, 2);
            end
            1: begin
               xs = $urandom_range(0, 2);
               ys = $urandom_range(6, 40);
               zs = $urandom_range(0, 2);
            end
            2: begin
               xs = $urandom_range(0, 2);
               ys = $urandom_range(0, 2);
               zs = $urandom_range(6, 40);
            end
            default: begin
               xs = $urandom_range(0, 5);
               ys = $urandom_range(0, 5);
               zs = $urandom_range(0, 5);
            end
         endcase
         set_volume(xs, ys, zs);
         total = axis_length(xs) * axis_length(ys) * axis_length(zs);
         if (total > 1 && $urandom_range(0, 5) == 0) begin
            part = $urandom_range(1, total - 1);
            run_voxels(part);
            settle();
            write_size(CSR_IDX_W'($urandom_range(0, 2)), $urandom_range(0, 5));
            sent += part;
            // volume end now depends on the new size, so go item by item
            while (volume_open) begin
               send_voxel(random_value());
               req_if.valid <= 1'b0;
               @(posedge clock);
               sent++;
            end
         end else begin
            // repeated volumes run back to back with results still in flight
            repeat ($urandom_range(1, 3)) begin
               run_voxels(total);
               sent += total;
            end
         end
         settle();
      end

      // one full row at the clamped size
      set_volume(BIG_SIZE, 0, 0);
      run_voxels(MAX_DIM);
      settle();

      // only the last write of a register counts
      write_size(CSR_Y_SIZE, BIG_SIZE);
      write_size(CSR_Z_SIZE, BIG_SIZE);
      set_volume(2, 3, 1);
      run_voxels(12);
      settle();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire
